### rtl/core/rmth_pkg.sv
// shared constants for the running median block
package rmth_pkg;

    localparam int SAMPLE_W = 32;
    localparam int MED_W    = 33;
    localparam int TOTAL_W  = 11;

    // which heap an operation targets
    localparam logic SEL_LOWER = 1'b0;
    localparam logic SEL_UPPER = 1'b1;

endpackage

### rtl/core/running_median_two_heaps.sv
// running median of a sample stream kept in a max-heap and a min-heap
// a sample is handled as an insert sift-up, then, while unbalanced, an optional pop sift-down
// and a push to the other heap; sift-up steps are S_UPRD and S_UPCMP, sift-down S_DNRD, S_DNL, S_DNCMP
// throughput: one sample at a time, the next accepted once the result is taken
// a sample that arrives when the total is 2*HEAP_DEPTH is dropped and flagged without an insert
// reset clears both fill counts; heap memories are not cleared
module running_median_two_heaps #(
    parameter int HEAP_DEPTH = 512
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [rmth_pkg::SAMPLE_W-1:0] sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [rmth_pkg::MED_W-1:0]    median_x2,
    output logic [$clog2(2*HEAP_DEPTH+1)-1:0]    sample_total,
    output logic                                 dropped
);
    import rmth_pkg::*;

    localparam int IDX_W = $clog2(HEAP_DEPTH + 2);
    localparam int TOT_W = $clog2(2 * HEAP_DEPTH + 1);

    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_INS  = 3'd1;
    localparam logic [2:0] C_BAL  = 3'd2;
    localparam logic [2:0] C_MOVE = 3'd3;
    localparam logic [2:0] C_OUT  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       mv_sel_reg, mv_sel_next;
    logic       drop_reg, drop_next;

    logic lo_push, lo_pop, up_push, up_pop, lo_busy, up_busy;
    logic signed [SAMPLE_W-1:0] lo_top, up_top, lo_val, up_val;
    logic [IDX_W-1:0] lo_cnt, up_cnt;

    rmth_heap #(.IDX_W(IDX_W), .DEPTH(HEAP_DEPTH + 1)) u_lo (
        .clk(clk), .rst_n(rst_n), .is_max(1'b1), .push(lo_push), .pop(lo_pop),
        .push_value(lo_val), .busy(lo_busy), .top(lo_top), .count(lo_cnt));

    rmth_heap #(.IDX_W(IDX_W), .DEPTH(HEAP_DEPTH + 1)) u_up (
        .clk(clk), .rst_n(rst_n), .is_max(1'b0), .push(up_push), .pop(up_pop),
        .push_value(up_val), .busy(up_busy), .top(up_top), .count(up_cnt));

    logic signed [SAMPLE_W-1:0] samp_reg, samp_next;
    logic [TOT_W-1:0] total;
    assign total = TOT_W'(lo_cnt) + TOT_W'(up_cnt);

    always_comb
    begin
        state_next  = state_reg;
        mv_sel_next = mv_sel_reg;
        drop_next   = drop_reg;
        samp_next   = samp_reg;
        lo_push = 1'b0; lo_pop = 1'b0; up_push = 1'b0; up_pop = 1'b0;
        lo_val  = samp_reg;
        up_val  = samp_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (in_valid)
                begin
                    samp_next = sample;
                    if (total >= TOT_W'(2 * HEAP_DEPTH))
                    begin
                        drop_next  = 1'b1;
                        state_next = C_OUT;
                    end
                    else
                    begin
                        drop_next  = 1'b0;
                        state_next = C_INS;
                    end
                end
            end
            C_INS:
            begin
                if (lo_cnt == '0 || samp_reg <= lo_top)
                begin
                    lo_push = 1'b1;
                end
                else
                begin
                    up_push = 1'b1;
                end
                state_next = C_BAL;
            end
            C_BAL:
            begin
                if (!lo_busy && !up_busy)
                begin
                    if (lo_cnt > up_cnt + IDX_W'(1))
                    begin
                        mv_sel_next = SEL_LOWER;
                        samp_next   = lo_top;
                        lo_pop      = 1'b1;
                        state_next  = C_MOVE;
                    end
                    else if (up_cnt > lo_cnt + IDX_W'(1))
                    begin
                        mv_sel_next = SEL_UPPER;
                        samp_next   = up_top;
                        up_pop      = 1'b1;
                        state_next  = C_MOVE;
                    end
                    else
                    begin
                        state_next = C_OUT;
                    end
                end
            end
            C_MOVE:
            begin
                // old top captured when the pop began; push it to the other side
                if (!lo_busy && !up_busy)
                begin
                    if (mv_sel_reg == SEL_LOWER)
                    begin
                        up_push = 1'b1;
                    end
                    else
                    begin
                        lo_push = 1'b1;
                    end
                    state_next = C_BAL;
                end
            end
            C_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mv_sel_reg <= mv_sel_next;
        drop_reg   <= drop_next;
        samp_reg   <= samp_next;
    end

    logic signed [MED_W-1:0] lo_x, up_x;
    assign lo_x = MED_W'(lo_top);
    assign up_x = MED_W'(up_top);

    always_comb
    begin
        if (lo_cnt == up_cnt)
        begin
            median_x2 = (lo_cnt == '0) ? '0 : lo_x + up_x;
        end
        else if (lo_cnt > up_cnt)
        begin
            median_x2 = lo_x <<< 1;
        end
        else
        begin
            median_x2 = up_x <<< 1;
        end
    end

    assign in_stall     = (state_reg != C_IDLE);
    assign out_valid    = (state_reg == C_OUT);
    assign sample_total = total;
    assign dropped      = drop_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !lo_busy && !up_busy)
        else $error("result shown while a heap is still sifting");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> lo_cnt <= up_cnt + IDX_W'(1) && up_cnt <= lo_cnt + IDX_W'(1))
        else $error("heaps out of balance at output");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dropped |-> total == TOT_W'(2 * HEAP_DEPTH))
        else $error("drop while storage not full");

endmodule

### rtl/core/rmth_heap.sv
// one heap held in a synchronous memory, with sift-up and sift-down sequencers
module rmth_heap #(
    parameter int IDX_W = 10,
    parameter int DEPTH = 513
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 is_max,
    input  logic                                 push,
    input  logic                                 pop,
    input  logic signed [rmth_pkg::SAMPLE_W-1:0] push_value,
    output logic                                 busy,
    output logic signed [rmth_pkg::SAMPLE_W-1:0] top,
    output logic [IDX_W-1:0]                     count
);
    import rmth_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UPRD   = 3'd1;
    localparam logic [2:0] S_UPCMP  = 3'd2;
    localparam logic [2:0] S_DNLAST = 3'd3;
    localparam logic [2:0] S_DNRD   = 3'd4;
    localparam logic [2:0] S_DNL    = 3'd5;
    localparam logic [2:0] S_DNCMP  = 3'd6;

    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic signed [SAMPLE_W-1:0] rd_data;
    logic [IDX_W-1:0]           rd_addr;
    logic                       rd_en;
    logic [IDX_W-1:0]           wr_addr;
    logic signed [SAMPLE_W-1:0] wr_data;
    logic                       wr_en;

    logic [2:0]                 state_reg, state_next;
    logic [IDX_W-1:0]           cnt_reg, cnt_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [IDX_W:0]             chl_reg, chl_next;
    logic signed [SAMPLE_W-1:0] val_reg, val_next;
    logic signed [SAMPLE_W-1:0] lv_reg, lv_next;
    logic signed [SAMPLE_W-1:0] top_reg, top_next;

    logic [IDX_W-1:0] parent;
    logic [IDX_W:0]   left_w;
    logic             win_b;

    function automatic logic outranks(input logic signed [SAMPLE_W-1:0] a,
                                      input logic signed [SAMPLE_W-1:0] b,
                                      input logic mx);
        outranks = mx ? (a > b) : (a < b);
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

    assign parent = (idx_reg - IDX_W'(1)) >> 1;
    assign left_w = {idx_reg, 1'b1};
    assign win_b  = outranks(rd_data, lv_reg, is_max);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        chl_next   = chl_reg;
        val_next   = val_reg;
        lv_next    = lv_reg;
        top_next   = top_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = val_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (push)
                begin
                    val_next = push_value;
                    idx_next = cnt_reg;
                    cnt_next = cnt_reg + IDX_W'(1);
                    if (cnt_reg == '0)
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = '0;
                        wr_data  = push_value;
                        top_next = push_value;
                    end
                    else
                    begin
                        state_next = S_UPRD;
                    end
                end
                else if (pop)
                begin
                    cnt_next = cnt_reg - IDX_W'(1);
                    rd_en    = 1'b1;
                    rd_addr  = cnt_reg - IDX_W'(1);
                    idx_next = '0;
                    state_next = S_DNLAST;
                end
            end
            // sift-up: hole at idx, pending value in val
            S_UPRD:
            begin
                if (idx_reg == '0)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = '0;
                    top_next = val_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = parent;
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP:
            begin
                if (outranks(val_reg, rd_data, is_max))
                begin
                    wr_en    = 1'b1;
                    wr_addr  = idx_reg;
                    wr_data  = rd_data;
                    idx_next = parent;
                    state_next = S_UPRD;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg;
                    state_next = S_IDLE;
                end
            end
            // sift-down: last entry becomes the value moving from the root
            S_DNLAST:
            begin
                val_next = rd_data;
                if (cnt_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    top_next = rd_data;
                    state_next = S_DNRD;
                end
            end
            S_DNRD:
            begin
                if (left_w >= {1'b0, cnt_reg})
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg;
                    if (idx_reg == '0)
                    begin
                        top_next = val_reg;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    chl_next = left_w;
                    rd_en    = 1'b1;
                    rd_addr  = left_w[IDX_W-1:0];
                    state_next = S_DNL;
                end
            end
            S_DNL:
            begin
                lv_next = rd_data;
                if (chl_reg + (IDX_W+1)'(1) < {1'b0, cnt_reg})
                begin
                    rd_en   = 1'b1;
                    rd_addr = chl_reg[IDX_W-1:0] + IDX_W'(1);
                    state_next = S_DNCMP;
                end
                else
                begin
                    // single child: compare it directly
                    if (outranks(rd_data, val_reg, is_max))
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = idx_reg;
                        wr_data  = rd_data;
                        if (idx_reg == '0)
                        begin
                            top_next = rd_data;
                        end
                        idx_next = chl_reg[IDX_W-1:0];
                        state_next = S_DNRD;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = idx_reg;
                        if (idx_reg == '0)
                        begin
                            top_next = val_reg;
                        end
                        state_next = S_IDLE;
                    end
                end
            end
            S_DNCMP:
            begin
                // right child wins only if it strictly outranks the left
                if (win_b)
                begin
                    if (outranks(rd_data, val_reg, is_max))
                    begin
                        wr_en   = 1'b1;
                        wr_addr = idx_reg;
                        wr_data = rd_data;
                        if (idx_reg == '0)
                        begin
                            top_next = rd_data;
                        end
                        idx_next = chl_reg[IDX_W-1:0] + IDX_W'(1);
                        state_next = S_DNRD;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = idx_reg;
                        if (idx_reg == '0)
                        begin
                            top_next = val_reg;
                        end
                        state_next = S_IDLE;
                    end
                end
                else if (outranks(lv_reg, val_reg, is_max))
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg;
                    wr_data = lv_reg;
                    if (idx_reg == '0)
                    begin
                        top_next = lv_reg;
                    end
                    idx_next = chl_reg[IDX_W-1:0];
                    state_next = S_DNRD;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg;
                    if (idx_reg == '0)
                    begin
                        top_next = val_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        chl_reg <= chl_next;
        val_reg <= val_next;
        lv_reg  <= lv_next;
        top_reg <= top_next;
    end

    assign busy  = (state_reg != S_IDLE);
    assign top   = top_reg;
    assign count = cnt_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) && push |=> cnt_reg == $past(cnt_reg) + IDX_W'(1))
        else $error("push did not grow the heap");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) && !push && pop |=> cnt_reg == $past(cnt_reg) - IDX_W'(1))
        else $error("pop did not shrink the heap");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> cnt_reg == $past(cnt_reg) || $past(state_reg) == S_IDLE)
        else $error("count changed mid-sift");

endmodule
